>>> hw/rtl/ors_pkg.sv
// Shared types, codes and constants for the online running statistics block.
package ors_pkg;

  localparam int unsigned SampleWidthDef = 32;
  localparam int unsigned CountWidthDef  = 32;
  localparam int unsigned DivW           = 64;
  localparam int unsigned SqrtSteps      = 40;
  localparam int unsigned SqrtRootW      = 40;
  localparam int unsigned SqrtRemW       = 44;
  localparam logic [63:0] MedianMinStep  = 64'd6554;

  // Statistic codes, shared by the mode register and the report field.
  localparam logic [3:0] MODE_OLDEST = 4'd0;
  localparam logic [3:0] MODE_NEWEST = 4'd1;
  localparam logic [3:0] MODE_MIN    = 4'd2;
  localparam logic [3:0] MODE_MAX    = 4'd3;
  localparam logic [3:0] MODE_MEAN   = 4'd4;
  localparam logic [3:0] MODE_SQDIST = 4'd5;
  localparam logic [3:0] MODE_VAR    = 4'd6;
  localparam logic [3:0] MODE_STDDEV = 4'd7;
  localparam logic [3:0] MODE_MEDIAN = 4'd8;

  // Action codes.
  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_REPORT = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] sample;
    logic [3:0]         report_mode;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               valid_res;
    logic [31:0]        sample_count;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic simple_upd;
    logic wel_start;
    logic mean_upd;
    logic sq_acc;
    logic rdiv_start;
    logic res_from_div;
    logic res_zero;
    logic sqrt_start;
    logic res_from_sqrt;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] stat_mode;
    logic [3:0] rep_mode;
    logic       have;
    logic       count_zero;
    logic       div_busy;
    logic       mul_busy;
    logic       sqrt_busy;
    logic       var_pos;
    logic       out_free;
  } status_t;

endpackage

>>> hw/rtl/ors_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module ors_div #(
  parameter int unsigned COUNT_WIDTH = ors_pkg::CountWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ors_pkg::DivW-1:0]    num_i,
  input  logic [COUNT_WIDTH-1:0]      den_i,
  output logic                        busy_o,
  output logic [ors_pkg::DivW-1:0]    quo_o
);

  localparam int unsigned NW    = ors_pkg::DivW;
  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic [NW-1:0]          num_q, num_d;
  logic [COUNT_WIDTH-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [COUNT_WIDTH+1:0] trial;
  logic [COUNT_WIDTH:0]   rem_sh;

  // Shift in one numerator bit and try the subtract.
  always_comb begin
    rem_sh = {rem_q, num_q[NW-1]};
    trial  = {1'b0, rem_sh} - {2'b00, den_i};
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      num_d = num_i;
      rem_d = '0;
      cnt_d = CNT_W'(NW);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (!trial[COUNT_WIDTH+1]) begin
        rem_d = trial[COUNT_WIDTH-1:0];
        num_d = {num_q[NW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[COUNT_WIDTH-1:0];
        num_d = {num_q[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = num_q;

endmodule

>>> hw/rtl/ors_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module ors_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        busy_o,
  output logic [63:0] root_o
);

  localparam int unsigned RW    = ors_pkg::SqrtRootW;
  localparam int unsigned MW    = ors_pkg::SqrtRemW;
  localparam int unsigned CNT_W = $clog2(ors_pkg::SqrtSteps + 1);

  logic [63:0]      x_q, x_d;
  logic [MW-1:0]    rem_q, rem_d;
  logic [RW-1:0]    root_q, root_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MW-1:0]    rem_sh;
  logic [MW-1:0]    trial;

  // Bring down the next bit pair and compare against the trial divisor.
  always_comb begin
    rem_sh = {rem_q[MW-3:0], x_q[63:62]};
    trial  = MW'({root_q, 2'b01});
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      x_d    = x_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNT_W'(ors_pkg::SqrtSteps);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      x_d   = {x_q[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[RW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = (cnt_q != '0);
  assign root_o = 64'(root_q);

endmodule

>>> hw/rtl/ors_dp.sv
// Datapath: statistic registers, update arithmetic, multiplier and output beat.
module ors_dp #(
  parameter int unsigned SAMPLE_WIDTH = ors_pkg::SampleWidthDef,
  parameter int unsigned COUNT_WIDTH  = ors_pkg::CountWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_wdata_i,
  input  ors_pkg::in_item_t in_data_i,
  input  ors_pkg::cmd_t     cmd_i,
  output ors_pkg::status_t  status_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ors_pkg::out_item_t out_data_o
);

  localparam int unsigned SW     = SAMPLE_WIDTH;
  localparam int unsigned CW     = COUNT_WIDTH;
  localparam int unsigned PROD_W = 2 * SW;
  localparam int unsigned MCNT_W = $clog2(SW + 1);
  localparam int unsigned EXT_W  = PROD_W + 64;
  localparam logic signed [65:0] SMAX66 = $signed((66'd1 << (SW - 1)) - 66'd1);
  localparam logic signed [65:0] SMIN66 = -SMAX66 - 66'sd1;
  localparam logic signed [63:0] I64MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] I64MIN = {1'b1, {63{1'b0}}};
  localparam logic [63:0] MedianMinStepLoc = ors_pkg::MedianMinStep;

  ors_pkg::in_item_t  in_q;
  ors_pkg::out_item_t out_q;
  logic               out_valid_q;
  logic [3:0]         stat_mode_q;
  logic signed [SW-1:0] first_q;
  logic signed [63:0] second_q;
  logic [CW-1:0]      count_q;
  logic               have_q;
  logic signed [SW:0] delta_q;
  logic signed [63:0] res_q;
  logic               div_neg_q;

  logic [PROD_W-1:0]  mul_acc_q, mul_mcand_q;
  logic [SW-1:0]      mul_mplier_q;
  logic [MCNT_W-1:0]  mul_cnt_q;
  logic               mul_neg_q;

  // Sample as a two's complement value of SAMPLE_WIDTH bits.
  logic [SW+31:0]       samp_ext;
  logic signed [SW-1:0] samp;
  assign samp_ext = {{SW{1'b0}}, in_q.sample};
  assign samp     = $signed(samp_ext[SW-1:0]);

  logic signed [63:0] samp64, first64;
  assign samp64  = {{(64-SW){samp[SW-1]}}, samp};
  assign first64 = {{(64-SW){first_q[SW-1]}}, first_q};

  logic [CW-1:0] count_inc;
  assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;

  // Median: move one step toward the sample, saturate, maybe halve the step.
  logic signed [65:0] med_f, med_s, med_step, med_w, med_wsat, med_diff, med_mag;
  logic signed [SW-1:0] med_new;
  logic               med_halve;
  logic [63:0]        med_init_mag;
  logic signed [63:0] med_init_step;
  always_comb begin
    med_f    = {{(66-SW){first_q[SW-1]}}, first_q};
    med_s    = {{(66-SW){samp[SW-1]}}, samp};
    med_step = {{2{second_q[63]}}, second_q};
    if (med_f > med_s) begin
      med_w = med_f - med_step;
    end else if (med_f < med_s) begin
      med_w = med_f + med_step;
    end else begin
      med_w = med_f;
    end
    if (med_w > SMAX66) begin
      med_wsat = SMAX66;
    end else if (med_w < SMIN66) begin
      med_wsat = SMIN66;
    end else begin
      med_wsat = med_w;
    end
    med_new   = med_wsat[SW-1:0];
    med_diff  = med_s - {{(66-SW){med_new[SW-1]}}, med_new};
    med_mag   = med_diff[65] ? -med_diff : med_diff;
    med_halve = med_step[65] || (med_mag < med_step);
    med_init_mag  = samp64[63] ? 64'(-samp64) : 64'(samp64);
    med_init_step = (med_init_mag >> 1) > MedianMinStepLoc ? $signed(med_init_mag >> 1)
                                                           : $signed(MedianMinStepLoc);
  end

  // Welford first half: distance from the current mean.
  logic signed [SW-1:0] first_eff;
  logic signed [63:0]   second_eff;
  logic signed [SW:0]   delta_w;
  logic [SW:0]          delta_mag;
  assign first_eff  = have_q ? first_q : '0;
  assign second_eff = have_q ? second_q : '0;
  assign delta_w    = {samp[SW-1], samp} - {first_eff[SW-1], first_eff};
  assign delta_mag  = delta_w[SW] ? -delta_w : delta_w;

  // Shared divider: numerator magnitude in, signed quotient out.
  logic [63:0]        div_num, div_quo, sec_mag;
  logic               div_busy;
  logic signed [63:0] quo_s;
  assign sec_mag = second_q[63] ? 64'(-second_q) : 64'(second_q);
  assign div_num = cmd_i.wel_start ? 64'(delta_mag) : sec_mag;
  assign quo_s   = div_neg_q ? -$signed(div_quo) : $signed(div_quo);

  ors_div #(.COUNT_WIDTH(CW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.wel_start || cmd_i.rdiv_start),
    .num_i  (div_num),
    .den_i  (count_q),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  // Welford second half: new mean and second distance.
  logic signed [SW-1:0] first_new;
  logic signed [SW:0]   delta2;
  logic [SW:0]          delta_q_mag, delta2_mag;
  assign first_new   = first_q + quo_s[SW-1:0];
  assign delta2      = {samp[SW-1], samp} - {first_new[SW-1], first_new};
  assign delta_q_mag = delta_q[SW] ? -delta_q : delta_q;
  assign delta2_mag  = delta2[SW] ? -delta2 : delta2;

  // Scaled product, saturated, then saturating accumulate.
  logic [EXT_W-1:0]   prod_ext;
  logic               prod_ovf;
  logic signed [63:0] term, sq_new;
  logic signed [64:0] sum65;
  always_comb begin
    prod_ext = EXT_W'(mul_acc_q);
    prod_ovf = |prod_ext[EXT_W-1:79];
    if (prod_ovf) begin
      term = mul_neg_q ? I64MIN : I64MAX;
    end else begin
      term = mul_neg_q ? -$signed({1'b0, prod_ext[78:16]}) : $signed({1'b0, prod_ext[78:16]});
    end
    sum65 = {second_q[63], second_q} + {term[63], term};
    if (sum65[64] != sum65[63]) begin
      sq_new = sum65[64] ? I64MIN : I64MAX;
    end else begin
      sq_new = sum65[63:0];
    end
  end

  logic [63:0] sqrt_root;
  logic        sqrt_busy;
  ors_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.sqrt_start),
    .x_i    (64'(quo_s)),
    .busy_o (sqrt_busy),
    .root_o (sqrt_root)
  );

  // Select the reported statistic.
  logic signed [63:0] rep_val;
  always_comb begin
    rep_val = '0;
    if (have_q) begin
      case (in_q.report_mode) inside
        ors_pkg::MODE_OLDEST, ors_pkg::MODE_NEWEST, ors_pkg::MODE_MIN,
        ors_pkg::MODE_MEAN, ors_pkg::MODE_MEDIAN: rep_val = first64;
        ors_pkg::MODE_MAX, ors_pkg::MODE_SQDIST:  rep_val = second_q;
        ors_pkg::MODE_VAR, ors_pkg::MODE_STDDEV:  rep_val = res_q;
        default:                                  rep_val = '0;
      endcase
    end
  end

  // Statistic state: config write, clear and updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_mode_q <= ors_pkg::MODE_NEWEST;
      first_q     <= '0;
      second_q    <= '0;
      count_q     <= '0;
      have_q      <= 1'b0;
    end else if (cfg_we_i) begin
      stat_mode_q <= cfg_wdata_i;
      first_q     <= '0;
      second_q    <= '0;
      count_q     <= '0;
      have_q      <= 1'b0;
    end else if (cmd_i.clear) begin
      first_q  <= '0;
      second_q <= '0;
      count_q  <= '0;
      have_q   <= 1'b0;
    end else if (cmd_i.simple_upd) begin
      have_q <= 1'b1;
      case (stat_mode_q) inside
        ors_pkg::MODE_OLDEST: begin
          if (!have_q) begin
            first_q <= samp;
            count_q <= count_inc;
          end
        end
        ors_pkg::MODE_NEWEST: first_q <= samp;
        ors_pkg::MODE_MIN, ors_pkg::MODE_MAX: begin
          count_q <= count_inc;
          if (!have_q) begin
            first_q  <= samp;
            second_q <= samp64;
          end else begin
            if (samp < first_q) first_q <= samp;
            if (samp64 > second_q) second_q <= samp64;
          end
        end
        default: begin
          count_q <= count_inc;
          if (!have_q) begin
            first_q  <= samp;
            second_q <= med_init_step;
          end else begin
            first_q <= med_new;
            if (med_halve) second_q <= second_q >>> 1;
          end
        end
      endcase
    end else if (cmd_i.wel_start) begin
      have_q   <= 1'b1;
      first_q  <= first_eff;
      second_q <= second_eff;
      count_q  <= count_inc;
    end else if (cmd_i.mean_upd) begin
      first_q <= first_new;
    end else if (cmd_i.sq_acc) begin
      second_q <= sq_new;
    end
  end

  // Hold the beat, operands and intermediate results.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= in_data_i;
    if (cmd_i.wel_start) begin
      delta_q   <= delta_w;
      div_neg_q <= delta_w[SW];
    end
    if (cmd_i.rdiv_start) div_neg_q <= second_q[63];
    if (cmd_i.res_from_div) res_q <= quo_s;
    if (cmd_i.res_zero) res_q <= '0;
    if (cmd_i.res_from_sqrt) res_q <= $signed(sqrt_root);
    if (cmd_i.out_load) begin
      out_q.value        <= rep_val;
      out_q.valid_res    <= have_q;
      out_q.sample_count <= 32'(count_q);
    end
  end

  // Shift-add multiplier on magnitudes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_cnt_q <= '0;
    end else if (cmd_i.mean_upd) begin
      mul_cnt_q <= MCNT_W'(SW);
    end else if (mul_cnt_q != '0) begin
      mul_cnt_q <= mul_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_upd) begin
      mul_acc_q    <= '0;
      mul_mcand_q  <= PROD_W'(delta_q_mag[SW-1:0]);
      mul_mplier_q <= delta2_mag[SW-1:0];
      mul_neg_q    <= delta_q[SW] ^ delta2[SW];
    end else if (mul_cnt_q != '0) begin
      if (mul_mplier_q[0]) mul_acc_q <= mul_acc_q + mul_mcand_q;
      mul_mcand_q  <= {mul_mcand_q[PROD_W-2:0], 1'b0};
      mul_mplier_q <= {1'b0, mul_mplier_q[SW-1:1]};
    end
  end

  // Output beat valid: set on load, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    status_o.action     = in_q.action;
    status_o.stat_mode  = stat_mode_q;
    status_o.rep_mode   = in_q.report_mode;
    status_o.have       = have_q;
    status_o.count_zero = (count_q == '0);
    status_o.div_busy   = div_busy;
    status_o.mul_busy   = (mul_cnt_q != '0);
    status_o.sqrt_busy  = sqrt_busy;
    status_o.var_pos    = !quo_s[63] && (quo_s != '0);
    status_o.out_free   = !out_valid_q || !out_stall_i;
  end

endmodule

>>> hw/rtl/ors_ctrl.sv
// Controller: sequences one beat through update, report and output.
module ors_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ors_pkg::status_t status_i,
  output ors_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_WDIV  = 3'd2;
  localparam logic [2:0] S_WMUL  = 3'd3;
  localparam logic [2:0] S_REP   = 3'd4;
  localparam logic [2:0] S_RDIV  = 3'd5;
  localparam logic [2:0] S_RSQRT = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       rep_derived;

  assign rep_derived = (status_i.rep_mode == ors_pkg::MODE_VAR) ||
                       (status_i.rep_mode == ors_pkg::MODE_STDDEV);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_REP;
        if (status_i.action == ors_pkg::ACT_SAMPLE) begin
          case (status_i.stat_mode) inside
            ors_pkg::MODE_OLDEST, ors_pkg::MODE_NEWEST, ors_pkg::MODE_MIN,
            ors_pkg::MODE_MAX, ors_pkg::MODE_MEDIAN: cmd_o.simple_upd = 1'b1;
            ors_pkg::MODE_MEAN, ors_pkg::MODE_SQDIST, ors_pkg::MODE_VAR,
            ors_pkg::MODE_STDDEV: begin
              cmd_o.wel_start = 1'b1;
              state_d         = S_WDIV;
            end
            default: state_d = S_REP;
          endcase
        end else if (status_i.action == ors_pkg::ACT_CLEAR) begin
          cmd_o.clear = 1'b1;
        end
      end
      S_WDIV: begin
        if (!status_i.div_busy) begin
          cmd_o.mean_upd = 1'b1;
          state_d        = S_WMUL;
        end
      end
      S_WMUL: begin
        if (!status_i.mul_busy) begin
          cmd_o.sq_acc = 1'b1;
          state_d      = S_REP;
        end
      end
      S_REP: begin
        state_d = S_OUT;
        if (rep_derived) begin
          if (status_i.have && !status_i.count_zero) begin
            cmd_o.rdiv_start = 1'b1;
            state_d          = S_RDIV;
          end else begin
            cmd_o.res_zero = 1'b1;
          end
        end
      end
      S_RDIV: begin
        if (!status_i.div_busy) begin
          if (status_i.rep_mode == ors_pkg::MODE_VAR) begin
            cmd_o.res_from_div = 1'b1;
            state_d            = S_OUT;
          end else if (status_i.var_pos) begin
            cmd_o.sqrt_start = 1'b1;
            state_d          = S_RSQRT;
          end else begin
            cmd_o.res_zero = 1'b1;
            state_d        = S_OUT;
          end
        end
      end
      S_RSQRT: begin
        if (!status_i.sqrt_busy) begin
          cmd_o.res_from_sqrt = 1'b1;
          state_d             = S_OUT;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

>>> hw/rtl/online_running_statistics.sv
// Top level of the online running statistics block.
// Min/max/oldest/newest/median samples and plain reports use no arithmetic unit;
// a Welford sample runs the divider and then the multiplier; a variance report runs
// the divider, and a std deviation report, for a positive variance, the square root after it.
// One beat at a time, paced by the bit-serial divider, multiplier and square-root
// units. Reset clears all statistics at once and sets the mode to newest; no
// clearing pass.
module online_running_statistics #(
  parameter int unsigned SAMPLE_WIDTH = ors_pkg::SampleWidthDef,
  parameter int unsigned COUNT_WIDTH  = ors_pkg::CountWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ors_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ors_pkg::out_item_t out_data_o
);

  ors_pkg::cmd_t    cmd;
  ors_pkg::status_t status;

  ors_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  ors_dp #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // No arithmetic unit runs while a new beat can be taken.
  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !(status.div_busy || status.mul_busy || status.sqrt_busy))
    else $error("arithmetic unit busy while idle");

  // An accepted beat blocks the next one.
  a_accept_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  // Before any sample the value reads zero.
  a_no_sample_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.valid_res) |-> (out_data_o.value == '0))
    else $error("nonzero value without sample");

  // A nonzero count implies a sample was taken.
  a_count_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.sample_count != '0)) |-> out_data_o.valid_res)
    else $error("count without sample");

endmodule
